>>> hw/rtl/elrp_pkg.sv
// ----------------------------------------------------------------------------
// Event log record packer package
// Shared constants, command and status types, and byte helpers.
// ----------------------------------------------------------------------------
package elrp_pkg;

  localparam int ADDRESS_BITS_DEF    = 8;
  localparam int MAX_FIELD_BYTES_DEF = 4;

  localparam logic [7:0] RECORD_BASE_RESET = 8'd13;

  localparam logic REG_BASE_TIME   = 1'b0;
  localparam logic REG_RECORD_BASE = 1'b1;

  localparam logic [2:0] K_HDR  = 3'd0;
  localparam logic [2:0] K_TIME = 3'd1;
  localparam logic [2:0] K_KEY  = 3'd2;
  localparam logic [2:0] K_CNT  = 3'd3;
  localparam logic [2:0] K_TRL  = 3'd4;
  localparam logic [2:0] K_COAL = 3'd5;

  typedef struct packed {
    logic       load_in;
    logic       calc;
    logic       emit;
    logic [2:0] kind;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       coal;
    logic       empty;
    logic [1:0] tl_m1;
    logic [1:0] kl_m1;
    logic       slot_free;
  } status_t;

  // Minimal byte count minus one, saturated to the field byte limit.
  function automatic logic [1:0] len_m1(input logic [31:0] v, input int max_bytes);
    logic [1:0] n;
    logic [1:0] lim;
    if (v[31:24] != 8'd0) n = 2'd3;
    else if (v[31:16] != 16'd0) n = 2'd2;
    else if (v[31:8] != 24'd0) n = 2'd1;
    else n = 2'd0;
    lim = 2'(max_bytes - 1);
    if (n > lim) n = lim;
    return n;
  endfunction

  function automatic logic [7:0] byte_sel(input logic [31:0] v, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = v[7:0];
      2'd1: b = v[15:8];
      2'd2: b = v[23:16];
      2'd3: b = v[31:24];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/elrp_ctrl.sv
// ----------------------------------------------------------------------------
// Event log record packer controller
// Sequences one event through evaluation and its store writes.
// ----------------------------------------------------------------------------
module elrp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  elrp_pkg::status_t sts,
  output elrp_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CALC   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_HDR    = 4'd3;
  localparam logic [3:0] S_TIME   = 4'd4;
  localparam logic [3:0] S_KEY    = 4'd5;
  localparam logic [3:0] S_CNT    = 4'd6;
  localparam logic [3:0] S_TRL    = 4'd7;
  localparam logic [3:0] S_COAL   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd.load_in = 1'b0;
    cmd.calc    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.kind    = elrp_pkg::K_HDR;
    cmd.idx     = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        idx_nxt = 2'd0;
        if (sts.coal && sts.empty) state_nxt = S_IDLE;
        else if (sts.coal) state_nxt = S_COAL;
        else state_nxt = S_HDR;
      end
      S_HDR: begin
        cmd.kind = elrp_pkg::K_HDR;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_TIME;
        end
      end
      S_TIME: begin
        cmd.kind = elrp_pkg::K_TIME;
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == sts.tl_m1) begin
            idx_nxt   = 2'd0;
            state_nxt = S_KEY;
          end
        end
      end
      S_KEY: begin
        cmd.kind = elrp_pkg::K_KEY;
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          idx_nxt  = idx_r + 2'd1;
          if (idx_r == sts.kl_m1) begin
            idx_nxt   = 2'd0;
            state_nxt = S_CNT;
          end
        end
      end
      S_CNT: begin
        cmd.kind = elrp_pkg::K_CNT;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_TRL;
        end
      end
      S_TRL: begin
        cmd.kind = elrp_pkg::K_TRL;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_COAL: begin
        cmd.kind = elrp_pkg::K_COAL;
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> hw/rtl/elrp_datapath.sv
// ----------------------------------------------------------------------------
// Event log record packer datapath
// Holds the log state, evaluates events and drives the output register.
// ----------------------------------------------------------------------------
module elrp_datapath #(
  parameter int ADDRESS_BITS    = elrp_pkg::ADDRESS_BITS_DEF,
  parameter int MAX_FIELD_BYTES = elrp_pkg::MAX_FIELD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       in_tdata,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  elrp_pkg::cmd_t    cmd,
  output elrp_pkg::status_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);

  localparam int AW = ADDRESS_BITS;

  logic [31:0]   base_time_r;
  logic [7:0]    record_base_r;
  logic [AW-1:0] tp_r;
  logic [31:0]   let_r;
  logic [31:0]   pk_r;
  logic [7:0]    cc_r;
  logic [3:0]    pl_r;
  logic [7:0]    rw_r;

  logic [31:0]   t_r, key_r, dt_r;
  logic [1:0]    tl_r, kl_r;
  logic          coal_r, empty_r;
  logic [3:0]    reclen_r;
  logic [AW-1:0] addr_r;

  logic          ov_r;
  logic [7:0]    o_addr_r, o_data_r, o_wp_r, o_ec_r;
  logic          o_last_r;

  logic [31:0]   elapsed, dt_c;
  logic [1:0]    tl_c, kl_c;
  logic          coal_c;
  logic [7:0]    e_data;
  logic [AW-1:0] e_addr;
  logic          e_last;
  logic [7:0]    cc_inc;

  assign elapsed = t_r - let_r;
  assign dt_c    = t_r - base_time_r;
  assign tl_c    = elrp_pkg::len_m1(dt_c, MAX_FIELD_BYTES);
  assign kl_c    = elrp_pkg::len_m1(key_r, MAX_FIELD_BYTES);
  assign coal_c  = (elapsed <= 32'd1) && ((key_r == 32'hffff_ffff) || (key_r == pk_r));
  assign cc_inc  = cc_r + 8'd1;

  assign sts.coal      = coal_r;
  assign sts.empty     = empty_r;
  assign sts.tl_m1     = tl_r;
  assign sts.kl_m1     = kl_r;
  assign sts.slot_free = !ov_r || out_tready;

  always_comb begin
    e_addr = addr_r;
    e_last = 1'b0;
    case (cmd.kind)
      elrp_pkg::K_HDR:  e_data = {tl_r, kl_r, pl_r};
      elrp_pkg::K_TIME: e_data = elrp_pkg::byte_sel(dt_r, cmd.idx);
      elrp_pkg::K_KEY:  e_data = elrp_pkg::byte_sel(key_r, cmd.idx);
      elrp_pkg::K_CNT:  e_data = 8'd1;
      elrp_pkg::K_TRL: begin
        e_data = {4'd0, reclen_r};
        e_last = 1'b1;
      end
      elrp_pkg::K_COAL: begin
        e_data = cc_inc;
        e_addr = tp_r - AW'(1);
        e_last = 1'b1;
      end
      default: e_data = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_r   <= in_tdata[31:0];
      key_r <= in_tdata[63:32];
    end
    if (cmd.calc) begin
      dt_r     <= dt_c;
      tl_r     <= tl_c;
      kl_r     <= kl_c;
      coal_r   <= coal_c;
      empty_r  <= (tp_r == AW'(record_base_r));
      reclen_r <= 4'(tl_c) + 4'(kl_c) + 4'd4;
      addr_r   <= tp_r;
    end else if (cmd.emit && (cmd.kind != elrp_pkg::K_COAL) && (cmd.kind != elrp_pkg::K_TRL)) begin
      addr_r <= addr_r + AW'(1);
    end
    if (cmd.emit) begin
      o_addr_r <= e_addr[7:0];
      o_data_r <= e_data;
      o_last_r <= e_last;
      if (cmd.kind == elrp_pkg::K_COAL) begin
        o_wp_r <= tp_r[7:0];
        o_ec_r <= rw_r;
      end else begin
        o_wp_r <= 8'(tp_r + AW'(tl_r) + AW'(kl_r) + AW'(4));
        o_ec_r <= rw_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r          <= 1'b0;
      base_time_r   <= 32'd0;
      record_base_r <= elrp_pkg::RECORD_BASE_RESET;
      tp_r          <= AW'(elrp_pkg::RECORD_BASE_RESET);
      let_r         <= 32'd0;
      pk_r          <= 32'd0;
      cc_r          <= 8'd0;
      pl_r          <= 4'd0;
      rw_r          <= 8'd0;
    end else begin
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          elrp_pkg::REG_BASE_TIME: begin
            base_time_r <= cfg_data;
            let_r       <= cfg_data;
          end
          elrp_pkg::REG_RECORD_BASE: begin
            record_base_r <= cfg_data[7:0];
            tp_r          <= AW'(cfg_data[7:0]);
          end
          default: begin
            base_time_r <= base_time_r;
          end
        endcase
      end
      if (cmd.emit && (cmd.kind == elrp_pkg::K_TRL)) begin
        tp_r  <= addr_r;
        pl_r  <= reclen_r;
        cc_r  <= 8'd1;
        let_r <= t_r;
        pk_r  <= key_r;
        rw_r  <= rw_r + 8'd1;
      end else if (cmd.emit && (cmd.kind == elrp_pkg::K_COAL)) begin
        cc_r  <= cc_inc;
        let_r <= t_r;
        pk_r  <= key_r;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {o_ec_r, o_wp_r, o_data_r, o_addr_r};
  assign out_tlast  = o_last_r;

endmodule

>>> hw/rtl/event_log_record_packer.sv
// ----------------------------------------------------------------------------
// Event log record packer
// Turns timestamped key events into a stream of byte writes for a log store.
// ----------------------------------------------------------------------------
// The input channel carries one key event per item. For each event the block
// emits the store writes it causes on the output channel, one byte per item,
// with tlast on the final write of the event. A repeat within one time unit of
// the previous event produces a single count update, or nothing if the log
// holds no record yet. A new record produces five to eleven writes.
// An event is accepted in idle and evaluated in the calc and decide states, then
// issues one write per cycle while the output register can take it; the controller
// handles one event at a time and the single output register sets the write rate.
// A stalled receiver holds the output register and the controller waits.
// The configuration port loads base_time and record_base; each also resets
// the matching log state. Reset empties the output register and restores the
// log to its start position at address 13 with no records.
// ----------------------------------------------------------------------------
module event_log_record_packer #(
  parameter int ADDRESS_BITS    = elrp_pkg::ADDRESS_BITS_DEF,
  parameter int MAX_FIELD_BYTES = elrp_pkg::MAX_FIELD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // event_time, key_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // write_address, write_data, write_pointer, entry_count
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  elrp_pkg::cmd_t    cmd;
  elrp_pkg::status_t sts;

  elrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  elrp_datapath #(
    .ADDRESS_BITS    (ADDRESS_BITS),
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_mid_record_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("controller idle while a record is unfinished");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("write issued while the output register is full");

endmodule
